@@ hdl/sts_pkg.sv @@
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, character constants and the keyword table of the SQL token
// scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int NUM_KW   = 18;
  localparam int KW_CHARS = 7;
  localparam int MAX_RES  = 4;
  localparam int CNT_W    = $clog2(MAX_RES + 1);
  localparam int IDX_W    = $clog2(MAX_RES);

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_WORD_HI = 8'hA0;
  localparam logic [7:0] CASE_GAP   = 8'h20;

  typedef enum logic [2:0] {
    KIND_TEXT    = 3'd0,
    KIND_KEYWORD = 3'd1,
    KIND_IDENT   = 3'd2,
    KIND_INT     = 3'd3,
    KIND_STRING  = 3'd4,
    KIND_DELIM   = 3'd5,
    KIND_EOS     = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ch;
    logic [4:0]  kw;
    logic [31:0] iv;
  } token_t;

  // tokens caused by one byte, item[0] goes out first
  typedef struct packed {
    logic [CNT_W-1:0]          count;
    token_t [MAX_RES-1:0]      item;
  } group_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] index;
  } kw_hit_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_word_start(input logic [7:0] b);
    return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
           ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ||
           (b >= CH_WORD_HI) || (b == CH_UNDER);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ? b + CASE_GAP : b;
  endfunction

  function automatic token_t make_tok(input kind_t kind, input logic [7:0] ch,
                                     input logic [4:0] kw, input logic [31:0] iv);
    token_t t;
    t.kind = kind;
    t.ch   = ch;
    t.kw   = kw;
    t.iv   = iv;
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    logic [3:0] l;
    unique case (k)
      5'd0, 5'd4, 5'd6, 5'd7, 5'd8, 5'd10: l = 4'd6;
      5'd1, 5'd5, 5'd14:                   l = 4'd4;
      5'd2, 5'd11, 5'd16:                  l = 4'd5;
      5'd3, 5'd9, 5'd12:                   l = 4'd3;
      5'd13:                               l = 4'd7;
      5'd15, 5'd17:                        l = 4'd2;
      default:                             l = 4'd0;
    endcase
    return l;
  endfunction

  // right-justified: first char of a keyword of length L sits in byte L-1
  function automatic logic [KW_CHARS-1:0][7:0] kw_text(input logic [4:0] k);
    logic [KW_CHARS-1:0][7:0] t;
    unique case (k)
      5'd0:    t = "select";
      5'd1:    t = "from";
      5'd2:    t = "where";
      5'd3:    t = "and";
      5'd4:    t = "insert";
      5'd5:    t = "into";
      5'd6:    t = "values";
      5'd7:    t = "delete";
      5'd8:    t = "update";
      5'd9:    t = "set";
      5'd10:   t = "create";
      5'd11:   t = "table";
      5'd12:   t = "int";
      5'd13:   t = "varchar";
      5'd14:   t = "view";
      5'd15:   t = "as";
      5'd16:   t = "index";
      5'd17:   t = "on";
      default: t = '0;
    endcase
    return t;
  endfunction

  // w[i] is the i-th char of the word; only the first len chars count
  function automatic kw_hit_t kw_lookup(input logic [KW_CHARS-1:0][7:0] w,
                                        input logic [7:0] len);
    kw_hit_t                  hit;
    logic [KW_CHARS-1:0][7:0] t;
    logic [3:0]               l;
    logic                     eq;
    logic [2:0]               pos;
    hit = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      t  = kw_text(5'(k));
      l  = kw_len(5'(k));
      eq = (len == {4'd0, l});
      for (int i = 0; i < KW_CHARS; i++) begin
        pos = (i < int'(l)) ? 3'(int'(l) - 1 - i) : 3'd0;
        if ((i < int'(l)) && (w[i] != t[pos])) eq = 1'b0;
      end
      if (eq) begin
        hit.hit   = 1'b1;
        hit.index = 5'(k);
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

@@ hdl/sts_scan.sv @@
// ----------------------------------------------------------------------------
// sts_scan
// Lexer state and the combinational step: one registered byte in, the group
// of tokens it causes out, state updated on step.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_scan
  import sts_pkg::*;
#(
  parameter int KEYWORD_MAX_LEN = 7
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] byte_q,
  input  wire logic       fin_q,
  output group_t          grp
);

  localparam int LEN_W = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int ADR_W = $clog2(KEYWORD_MAX_LEN);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(KEYWORD_MAX_LEN);

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_MINUS  = 5'b00010,
    MODE_NUMBER = 5'b00100,
    MODE_WORD   = 5'b01000,
    MODE_STRING = 5'b10000
  } mode_t;

  mode_t             mode, mode_next;
  logic              quote_dbl, quote_dbl_next;
  logic [31:0]       acc, acc_next;        // signed value so far
  logic              neg, neg_next;
  logic [LEN_W-1:0]  word_len, word_len_next;
  logic [7:0]        word_store [KEYWORD_MAX_LEN];

  logic              dig, wst, rescan, add_ch;
  logic [LEN_W-1:0]  add_base, len_added;
  logic              we;
  logic [ADR_W-1:0]  waddr;
  logic [7:0]        wdata;
  logic [31:0]       dval, acc_x10;

  logic [KW_CHARS-1:0][7:0] cur_w, nxt_w;
  kw_hit_t           cur_hit, nxt_hit;
  logic [CNT_W-1:0]  n;

  assign dig     = is_digit(byte_q);
  assign wst     = is_word_start(byte_q);
  assign dval    = 32'(4'(byte_q - CH_ZERO));
  assign acc_x10 = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};

  // char append to the word buffer
  always_comb begin
    rescan   = 1'b0;
    add_ch   = 1'b0;
    add_base = word_len;
    unique case (mode)
      MODE_STRING: rescan = 1'b0;
      MODE_MINUS:  rescan = !dig;
      MODE_NUMBER: rescan = !dig;
      MODE_WORD:   rescan = !(wst || dig);
      default:     rescan = 1'b1;
    endcase
    if (mode == MODE_WORD && (wst || dig)) begin
      add_ch = 1'b1;
    end else if (rescan && wst) begin
      add_ch   = 1'b1;
      add_base = '0;
    end
    we        = add_ch && (add_base < LEN_MAX);
    waddr     = add_base[ADR_W-1:0];
    wdata     = to_lower(byte_q);
    len_added = (add_base <= LEN_MAX) ? add_base + LEN_W'(1) : add_base;
  end

  for (genvar i = 0; i < KW_CHARS; i++) begin : g_view
    assign cur_w[i] = word_store[i];
    assign nxt_w[i] = (we && waddr == ADR_W'(i)) ? wdata : word_store[i];
  end

  assign cur_hit = kw_lookup(cur_w, 8'(word_len));
  assign nxt_hit = kw_lookup(nxt_w, 8'(len_added));

  always_comb begin
    grp            = '0;
    n              = '0;
    mode_next      = mode;
    quote_dbl_next = quote_dbl;
    acc_next       = acc;
    neg_next       = neg;
    word_len_next  = add_ch ? len_added : word_len;

    // close or continue the open token
    unique case (mode)
      MODE_STRING: begin
        if (byte_q == (quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
          grp.item[n[IDX_W-1:0]] = make_tok(KIND_STRING, 8'd0, 5'd0, 32'd0);
          n = n + CNT_W'(1);
          mode_next = MODE_IDLE;
        end else begin
          grp.item[n[IDX_W-1:0]] = make_tok(KIND_TEXT, byte_q, 5'd0, 32'd0);
          n = n + CNT_W'(1);
        end
      end
      MODE_MINUS: begin
        if (dig) begin
          acc_next  = 32'd0 - dval;
          mode_next = MODE_NUMBER;
        end else begin
          grp.item[n[IDX_W-1:0]] = make_tok(KIND_DELIM, CH_MINUS, 5'd0, 32'd0);
          n = n + CNT_W'(1);
        end
      end
      MODE_NUMBER: begin
        if (dig) begin
          acc_next = neg ? acc_x10 - dval : acc_x10 + dval;
        end else begin
          grp.item[n[IDX_W-1:0]] = make_tok(KIND_INT, 8'd0, 5'd0, acc);
          n = n + CNT_W'(1);
        end
      end
      MODE_WORD: begin
        if (!(wst || dig)) begin
          if (cur_hit.hit) begin
            grp.item[n[IDX_W-1:0]] = make_tok(KIND_KEYWORD, 8'd0, cur_hit.index, 32'd0);
          end else begin
            grp.item[n[IDX_W-1:0]] = make_tok(KIND_IDENT, 8'd0, 5'd0, 32'd0);
          end
          n = n + CNT_W'(1);
        end
      end
      default: mode_next = MODE_IDLE;
    endcase

    // byte scanned from idle
    if (rescan) begin
      mode_next = MODE_IDLE;
      if (byte_q > CH_SPACE) begin
        if (byte_q == CH_DQUOTE || byte_q == CH_SQUOTE) begin
          mode_next      = MODE_STRING;
          quote_dbl_next = (byte_q == CH_DQUOTE);
        end else if (byte_q == CH_MINUS) begin
          mode_next = MODE_MINUS;
          neg_next  = 1'b1;
          acc_next  = 32'd0;
        end else if (dig) begin
          mode_next = MODE_NUMBER;
          neg_next  = 1'b0;
          acc_next  = dval;
        end else if (wst) begin
          mode_next = MODE_WORD;
        end else begin
          grp.item[n[IDX_W-1:0]] = make_tok(KIND_DELIM, byte_q, 5'd0, 32'd0);
          n = n + CNT_W'(1);
        end
      end
    end

    if (add_ch) begin
      grp.item[n[IDX_W-1:0]] = make_tok(KIND_TEXT, wdata, 5'd0, 32'd0);
      n = n + CNT_W'(1);
    end

    // last byte: flush, end of stream, back to reset
    if (fin_q) begin
      unique case (mode_next)
        MODE_MINUS: begin
          grp.item[n[IDX_W-1:0]] = make_tok(KIND_DELIM, CH_MINUS, 5'd0, 32'd0);
          n = n + CNT_W'(1);
        end
        MODE_NUMBER: begin
          grp.item[n[IDX_W-1:0]] = make_tok(KIND_INT, 8'd0, 5'd0, acc_next);
          n = n + CNT_W'(1);
        end
        MODE_WORD: begin
          if (nxt_hit.hit) begin
            grp.item[n[IDX_W-1:0]] = make_tok(KIND_KEYWORD, 8'd0, nxt_hit.index, 32'd0);
          end else begin
            grp.item[n[IDX_W-1:0]] = make_tok(KIND_IDENT, 8'd0, 5'd0, 32'd0);
          end
          n = n + CNT_W'(1);
        end
        default: ;
      endcase
      grp.item[n[IDX_W-1:0]] = make_tok(KIND_EOS, 8'd0, 5'd0, 32'd0);
      n = n + CNT_W'(1);
      mode_next      = MODE_IDLE;
      quote_dbl_next = 1'b0;
      acc_next       = 32'd0;
      neg_next       = 1'b0;
      word_len_next  = '0;
    end

    grp.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      quote_dbl <= 1'b0;
      acc       <= 32'd0;
      neg       <= 1'b0;
      word_len  <= '0;
    end else if (step) begin
      mode      <= mode_next;
      quote_dbl <= quote_dbl_next;
      acc       <= acc_next;
      neg       <= neg_next;
      word_len  <= word_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && we) begin
      word_store[waddr] <= wdata;
    end
  end

  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    step && fin_q |=> mode == MODE_IDLE && word_len == '0 && acc == 32'd0 && !neg)
    else $error("state not cleared after last byte");

  a_len_sat: assert property (@(posedge clk) disable iff (rst)
    word_len <= LEN_MAX + LEN_W'(1))
    else $error("word length beyond saturation");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    step && fin_q |-> grp.count != '0)
    else $error("last byte without end of stream");

endmodule

`default_nettype wire

@@ hdl/sts_drain.sv @@
// ----------------------------------------------------------------------------
// sts_drain
// Result register: holds the token group of one byte and hands it out one
// word per cycle while token_stall is low.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_drain
  import sts_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire group_t       grp_in,
  output logic              free,
  output logic              token_valid,
  input  wire logic         token_stall,
  output logic [2:0]        kind,
  output logic [7:0]        char_value,
  output logic [4:0]        keyword_index,
  output logic signed [31:0] int_value,
  output logic              run_end
);

  group_t           grp;
  logic             full;
  logic [IDX_W-1:0] idx;
  logic             take, last, done;
  token_t           cur;

  assign cur  = grp.item[idx];
  assign take = full && !token_stall;
  assign last = (CNT_W'(idx) == grp.count - CNT_W'(1));
  assign done = take && last;
  assign free = !full || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (done) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  assign token_valid   = full;
  assign kind          = cur.kind;
  assign char_value    = cur.ch;
  assign keyword_index = cur.kw;
  assign int_value     = $signed(cur.iv);
  assign run_end       = last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    full |-> grp.count != '0 && grp.count <= CNT_W'(MAX_RES))
    else $error("held group has bad count");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    full |-> CNT_W'(idx) < grp.count)
    else $error("read index past group");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    load |-> free && grp_in.count != '0)
    else $error("group loaded over a pending one");

endmodule

`default_nettype wire

@@ hdl/sql_token_scanner.sv @@
// ----------------------------------------------------------------------------
// sql_token_scanner
// Streaming SQL lexer: one query byte in, zero to four tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid/byte_stall): byte_req plus final_req, which marks
//   the last byte of a query. Token channel (token_valid/token_stall): kind,
//   char_value, keyword_index, int_value, and run_end on the last token word
//   caused by one byte. Bytes that cause no token (separators, opening
//   quotes, digits inside a number) produce nothing on the token side.
//   The input register holds a taken byte; once the result register is free,
//   its token group is loaded there and its first token word is offered.
//   Throughput: one byte per cycle while each byte yields at most one token
//   and token_stall is low. A byte yielding more holds the result register
//   until its last token word is taken while the next byte waits in the input
//   register; the result register (one group deep) is what limits the rate.
//   Stall: a stalled token holds still; byte_stall is high while the input
//   register holds a byte and the result register keeps words past this cycle.
//   Reset (rst, synchronous): both registers empty, scanner idle, no pending
//   token. The last byte of a query also returns the scanner to that state.
//   Words longer than KEYWORD_MAX_LEN are never keywords.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_token_scanner
  import sts_pkg::*;
#(
  parameter int KEYWORD_MAX_LEN = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          byte_valid,
  output logic               byte_stall,
  input  wire logic [7:0]    byte_req,
  input  wire logic          final_req,
  output logic               token_valid,
  input  wire logic          token_stall,
  output logic [2:0]         kind,
  output logic [7:0]         char_value,
  output logic [4:0]         keyword_index,
  output logic signed [31:0] int_value,
  output logic               run_end
);

  // input register
  logic       in_full;
  logic [7:0] byte_q;
  logic       fin_q;

  logic       free;      // result register can take a group this cycle
  logic       step;      // registered byte is scanned and retired
  logic       byte_take;
  group_t     grp;

  assign step       = in_full && free;
  assign byte_stall = in_full && !free;
  assign byte_take  = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_take) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take) begin
      byte_q <= byte_req;
      fin_q  <= final_req;
    end
  end

  // lexer state and token group for the registered byte
  sts_scan #(
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .byte_q (byte_q),
    .fin_q  (fin_q),
    .grp    (grp)
  );

  // group register, one token word per cycle unless stalled; empty groups skip it
  sts_drain u_drain (
    .clk           (clk),
    .rst           (rst),
    .load          (step && grp.count != '0),
    .grp_in        (grp),
    .free          (free),
    .token_valid   (token_valid),
    .token_stall   (token_stall),
    .kind          (kind),
    .char_value    (char_value),
    .keyword_index (keyword_index),
    .int_value     (int_value),
    .run_end       (run_end)
  );

endmodule

`default_nettype wire
